FILE: hw/rtl/dsu_pkg.sv
// Shared types and constants for the decimal string to unsigned integer parser.
`timescale 1ns / 1ps
`default_nettype none

package dsu_pkg;

  // Width of one text byte and of the result value port.
  localparam int CHAR_BITS = 8;
  localparam int NUM_BITS  = 32;

  // Default width of the internal accumulator.
  localparam int VALUE_BITS_DEFAULT = 32;

  // Character codes that the parser recognizes.
  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

  // Bits that one decimal digit needs.
  localparam int DIGIT_BITS = 4;

  // Position of the parser within one string.
  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TRAIL  = 2'd2
  } phase_t;

  // One finished result item.
  typedef struct packed {
    logic [NUM_BITS-1:0] number_value;
    logic                is_number;
    logic                converted;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsu_in_reg.sv
// Input register stage that holds one text byte until the parser consumes it.
`timescale 1ns / 1ps
`default_nettype none

module dsu_in_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dsu_pkg::CHAR_BITS-1:0] ch,
  input  wire logic                          advance,
  output logic                               stage_valid,
  output logic      [dsu_pkg::CHAR_BITS-1:0] stage_ch
);

  // The stage can take a new item when it is empty or its item moves on now.
  assign in_ready = !stage_valid || advance;

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Held byte.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_ch <= ch;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dsu_core.sv
// Parser state and the per-byte classification and accumulate logic.
`timescale 1ns / 1ps
`default_nettype none

module dsu_core #(
  parameter int VALUE_BITS = dsu_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [dsu_pkg::CHAR_BITS-1:0] stage_ch,
  output logic                               is_nul,
  output dsu_pkg::result_t                   res
);

  localparam int WIDE_BITS = VALUE_BITS + dsu_pkg::DIGIT_BITS;

  dsu_pkg::phase_t         phase, phase_next;
  logic [VALUE_BITS-1:0]   accumulator, accumulator_next;
  logic                    bad_char_seen, bad_char_seen_next;
  logic                    overflow_seen, overflow_seen_next;

  logic                    is_blank;
  logic                    is_digit;
  logic [dsu_pkg::DIGIT_BITS-1:0] digit;
  logic [WIDE_BITS-1:0]    acc_wide;
  logic [WIDE_BITS-1:0]    product;
  logic                    product_ovf;
  logic                    num;
  logic                    conv;

  // Classify the byte.
  assign is_nul   = (stage_ch == dsu_pkg::CH_NUL);
  assign is_blank = (stage_ch == dsu_pkg::CH_SPACE) || (stage_ch == dsu_pkg::CH_TAB);
  assign is_digit = (stage_ch >= dsu_pkg::CH_ZERO) && (stage_ch <= dsu_pkg::CH_NINE);
  assign digit    = dsu_pkg::DIGIT_BITS'(stage_ch - dsu_pkg::CH_ZERO);

  // Times ten as shift and add; any carry into the top bits is an overflow.
  assign acc_wide    = WIDE_BITS'(accumulator);
  assign product     = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(digit);
  assign product_ovf = |product[WIDE_BITS-1:VALUE_BITS];

  // Next state.
  always_comb begin
    phase_next         = phase;
    accumulator_next   = accumulator;
    bad_char_seen_next = bad_char_seen;
    overflow_seen_next = overflow_seen;
    if (step) begin
      if (is_nul) begin
        phase_next         = dsu_pkg::PH_LEAD;
        accumulator_next   = '0;
        bad_char_seen_next = 1'b0;
        overflow_seen_next = 1'b0;
      end else if (is_blank) begin
        if (phase == dsu_pkg::PH_DIGITS) begin
          phase_next = dsu_pkg::PH_TRAIL;
        end
      end else if (is_digit) begin
        unique case (phase)
          dsu_pkg::PH_LEAD, dsu_pkg::PH_DIGITS: begin
            phase_next = dsu_pkg::PH_DIGITS;
            if (!bad_char_seen && !overflow_seen) begin
              if (product_ovf) begin
                overflow_seen_next = 1'b1;
              end else begin
                accumulator_next = product[VALUE_BITS-1:0];
              end
            end
          end
          default: begin
            // A digit after trailing blanks splits the number.
            bad_char_seen_next = 1'b1;
          end
        endcase
      end else begin
        bad_char_seen_next = 1'b1;
      end
    end
  end

  // Result of the string as it stands; taken only on the terminating byte.
  always_comb begin
    num                  = (phase != dsu_pkg::PH_LEAD) && !bad_char_seen;
    conv                 = num && !overflow_seen;
    res.is_number        = num;
    res.converted        = conv;
    res.number_value     = conv ? dsu_pkg::NUM_BITS'(accumulator) : '0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dsu_pkg::PH_LEAD;
      accumulator   <= '0;
      bad_char_seen <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      phase         <= phase_next;
      accumulator   <= accumulator_next;
      bad_char_seen <= bad_char_seen_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dsu_out_reg.sv
// Result register that holds one finished item until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module dsu_out_reg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire dsu_pkg::result_t             res,
  output logic                              space,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [dsu_pkg::NUM_BITS-1:0] number_value,
  output logic                              is_number,
  output logic                              converted
);

  dsu_pkg::result_t held;

  // The register can be loaded when empty or when its item leaves now.
  assign space = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  // Held result.
  always_ff @(posedge clk) begin
    if (load && space) begin
      held <= res;
    end
  end

  assign number_value = held.number_value;
  assign is_number    = held.is_number;
  assign converted    = held.converted;

endmodule

`default_nettype wire

FILE: hw/rtl/decimal_string_to_uint_parser.sv
// Top level of the decimal string to unsigned integer parser.
// Usage:
//   The input channel (in_valid, in_ready, ch) carries one text byte per item.
//   Leading and trailing spaces and tabs are ignored; a NUL byte ends the
//   string and yields exactly one result item on the output channel
//   (out_valid, out_ready, number_value, is_number, converted). Other bytes
//   yield no result.
//   Throughput is one byte per cycle. A byte is registered on acceptance and
//   classified and accumulated in the following cycle, where the times-ten
//   step is a shift and add into a VALUE_BITS+4 bit adder.
//   After acceptance, a NUL passes from the input register to the result register, which raises out_valid.
//   When the receiver stalls, non-NUL bytes are still taken every cycle; a
//   NUL waits in the input register until the result register frees up, and
//   in_ready then drops for as long as the stall lasts.
//   Reset clears all parse state and both valid flags; the block is ready
//   for a new string in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module decimal_string_to_uint_parser #(
  parameter int VALUE_BITS = dsu_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dsu_pkg::CHAR_BITS-1:0] ch,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [dsu_pkg::NUM_BITS-1:0]  number_value,
  output logic                               is_number,
  output logic                               converted
);

  logic                          stage_valid;
  logic [dsu_pkg::CHAR_BITS-1:0] stage_ch;
  logic                          is_nul;
  logic                          space;
  logic                          advance;
  dsu_pkg::result_t              res;

  // A held byte moves on unless it is a NUL facing a full result register.
  assign advance = stage_valid && (!is_nul || space);

  dsu_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_ch    (stage_ch)
  );

  dsu_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .stage_ch (stage_ch),
    .is_nul   (is_nul),
    .res      (res)
  );

  dsu_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && is_nul),
    .res          (res),
    .space        (space),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .number_value (number_value),
    .is_number    (is_number),
    .converted    (converted)
  );

  // A converted result is always a number.
  a_conv_is_number: assert property (@(posedge clk) disable iff (rst)
    out_valid && converted |-> is_number)
    else $error("converted result that is not a number");

  // A result that did not convert carries a zero value.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !converted |-> number_value == '0)
    else $error("nonzero value on unconverted result");

  // A NUL that moves on shows up as a result in the next cycle.
  a_nul_result: assert property (@(posedge clk) disable iff (rst)
    advance && is_nul |=> out_valid)
    else $error("terminating byte produced no result");

  // A byte other than NUL never holds up the input.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !is_nul |-> in_ready)
    else $error("input stalled behind a non-terminating byte");

endmodule

`default_nettype wire

FILE: tb/number_parse_checker.sv
// Checker that predicts and compares the parser's result items.
`timescale 1ns / 1ps

module number_parse_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [dsu_pkg::CHAR_BITS-1:0] ch,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [dsu_pkg::NUM_BITS-1:0]  number_value,
  input  wire logic                          is_number,
  input  wire logic                          converted,
  output int                                 fail_count,
  output int                                 pending_results
);

  localparam int ACC_BITS = dsu_pkg::VALUE_BITS_DEFAULT;

  // Parse state of the string currently arriving.
  logic [ACC_BITS-1:0] acc_value;
  dsu_pkg::phase_t     parse_phase;
  logic                bad_seen;
  logic                ovf_seen;

  // Results owed by the block, oldest first.
  dsu_pkg::result_t expected_numbers[$];

  function automatic void clear_parse();
    acc_value   = '0;
    parse_phase = dsu_pkg::PH_LEAD;
    bad_seen    = 1'b0;
    ovf_seen    = 1'b0;
  endfunction

  // Advance the parse by one text byte; a NUL closes the string and owes a result.
  function automatic void parse_char(input logic [dsu_pkg::CHAR_BITS-1:0] c);
    logic [ACC_BITS+3:0] scaled;
    dsu_pkg::result_t    res;
    if (c == dsu_pkg::CH_NUL) begin
      res.is_number    = (parse_phase != dsu_pkg::PH_LEAD) && !bad_seen;
      res.converted    = res.is_number && !ovf_seen;
      res.number_value = res.converted ? dsu_pkg::NUM_BITS'(acc_value) : '0;
      expected_numbers.push_back(res);
      clear_parse();
    end else if (c == dsu_pkg::CH_SPACE || c == dsu_pkg::CH_TAB) begin
      if (parse_phase == dsu_pkg::PH_DIGITS) begin
        parse_phase = dsu_pkg::PH_TRAIL;
      end
    end else if (c >= dsu_pkg::CH_ZERO && c <= dsu_pkg::CH_NINE) begin
      if (parse_phase == dsu_pkg::PH_TRAIL) begin
        // A digit after a blank that followed digits breaks the number.
        bad_seen = 1'b1;
      end else begin
        parse_phase = dsu_pkg::PH_DIGITS;
        if (!bad_seen && !ovf_seen) begin
          scaled = (ACC_BITS + 4)'(acc_value) * 10
                   + (ACC_BITS + 4)'(c - dsu_pkg::CH_ZERO);
          if ((scaled >> ACC_BITS) != 0) begin
            ovf_seen = 1'b1;
          end else begin
            acc_value = scaled[ACC_BITS-1:0];
          end
        end
      end
    end else begin
      bad_seen = 1'b1;
    end
  endfunction

  // Compare one result item with the oldest expectation.
  function automatic void check_result();
    dsu_pkg::result_t exp_res;
    if (expected_numbers.size() == 0) begin
      $display("%0t: unexpected result item: value %0d is_number %0b converted %0b",
               $time, number_value, is_number, converted);
      fail_count++;
    end else begin
      exp_res = expected_numbers.pop_front();
      if (number_value !== exp_res.number_value) begin
        $display("%0t: number_value expected %0d actual %0d",
                 $time, exp_res.number_value, number_value);
        fail_count++;
      end
      if (is_number !== exp_res.is_number) begin
        $display("%0t: is_number expected %0b actual %0b",
                 $time, exp_res.is_number, is_number);
        fail_count++;
      end
      if (converted !== exp_res.converted) begin
        $display("%0t: converted expected %0b actual %0b",
                 $time, exp_res.converted, converted);
        fail_count++;
      end
    end
  endfunction

  // Outputs are checked before inputs: a result leaving at this edge is always
  // older than a NUL arriving at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_numbers.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_result();
      end
      if (in_valid && in_ready) begin
        parse_char(ch);
      end
    end
    pending_results = expected_numbers.size();
  end

endmodule

FILE: tb/decimal_string_to_uint_parser_test.sv
// Top of the parser testbench: clock, reset, text stimulus, receiver and verdict.
`timescale 1ns / 1ps

module decimal_string_to_uint_parser_test;

  localparam int RANDOM_CHARS = 1350;
  localparam int HOLD_CYCLES  = 300;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [dsu_pkg::CHAR_BITS-1:0] ch        = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [dsu_pkg::NUM_BITS-1:0]  number_value;
  logic                          is_number;
  logic                          converted;
  int                            fail_count;
  int                            pending_results;

  // Stimulus control shared with the receiver.
  int                            tx_idle_pct   = 0;
  int                            rx_idle_pct   = 0;
  int                            hold_requests = 0;
  int                            holds_served  = 0;
  int                            hold_left     = 0;
  int                            sent_chars    = 0;
  int                            random_goal;
  logic [dsu_pkg::CHAR_BITS-1:0] text[$];

  decimal_string_to_uint_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .number_value (number_value),
    .is_number    (is_number),
    .converted    (converted)
  );

  number_parse_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .ch              (ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .number_value    (number_value),
    .is_number       (is_number),
    .converted       (converted),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one text byte, idling first at random, and wait until it is taken.
  task automatic offer_char(input logic [dsu_pkg::CHAR_BITS-1:0] c);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_chars++;
  endtask

  // Send the buffered text followed by its NUL.
  task automatic offer_text();
    foreach (text[i]) offer_char(text[i]);
    offer_char(dsu_pkg::CH_NUL);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic load_text(input string s);
    text.delete();
    append_text(s);
  endtask

  task automatic push_blanks(input int n);
    repeat (n) text.push_back($urandom_range(0, 1) ? dsu_pkg::CH_SPACE : dsu_pkg::CH_TAB);
  endtask

  task automatic push_digits(input int n);
    repeat (n) text.push_back(dsu_pkg::CH_ZERO + dsu_pkg::CHAR_BITS'($urandom_range(0, 9)));
  endtask

  // Any nonzero byte that is neither a digit nor a blank.
  function automatic logic [dsu_pkg::CHAR_BITS-1:0] stray_char();
    logic [dsu_pkg::CHAR_BITS-1:0] c;
    do begin
      c = dsu_pkg::CHAR_BITS'($urandom_range(1, 255));
    end while ((c >= dsu_pkg::CH_ZERO && c <= dsu_pkg::CH_NINE) ||
               c == dsu_pkg::CH_SPACE || c == dsu_pkg::CH_TAB);
    return c;
  endfunction

  // Build one random string: mostly well-formed numbers, some near the top of
  // the range, some broken numbers and some plain noise.
  task automatic make_random_text();
    int kind;
    text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      push_blanks($urandom_range(0, 3));
      push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8));
      push_blanks($urandom_range(0, 3));
    end else if (kind < 70) begin
      // Values from 4294960000 to 4294969999 straddle the overflow point.
      push_blanks($urandom_range(0, 1));
      append_text("429496");
      push_digits(4);
      push_blanks($urandom_range(0, 1));
    end else if (kind < 85) begin
      push_blanks($urandom_range(0, 2));
      push_digits($urandom_range(1, 5));
      if ($urandom_range(0, 1)) begin
        push_blanks($urandom_range(1, 2));
      end else begin
        text.push_back(stray_char());
      end
      push_digits($urandom_range(1, 5));
      push_blanks($urandom_range(0, 2));
    end else begin
      repeat ($urandom_range(0, 6)) text.push_back(dsu_pkg::CHAR_BITS'($urandom_range(1, 255)));
    end
  endtask

  // Stop offering and wait until every owed result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off for each request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Main stimulus and verdict.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: empty, all blank, blanks around a digit, a single zero,
    // the largest value, the first overflowing value, a blank between digits
    // and a bad byte ahead of a digit.
    tx_idle_pct = 9;
    rx_idle_pct = 80;
    load_text("");           offer_text();
    load_text(" \t");        offer_text();
    load_text("\t7 ");       offer_text();
    load_text("0");          offer_text();
    load_text("4294967295"); offer_text();
    load_text("4294967296"); offer_text();
    load_text("1 2");        offer_text();
    load_text("/9");         offer_text();
    drain_results();

    // Random strings in three idling regimes; the last one starts with a long
    // receiver hold-off while the sender keeps going at full rate.
    for (int regime = 0; regime < 3; regime++) begin
      tx_idle_pct = (regime == 0) ? 9 : (regime == 1) ? 80 : 0;
      rx_idle_pct = (regime == 0) ? 80 : (regime == 1) ? 9 : 0;
      if (regime == 2) hold_requests++;
      random_goal = sent_chars + RANDOM_CHARS / 3;
      while (sent_chars < random_goal) begin
        make_random_text();
        offer_text();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("decimal_string_to_uint_parser verification clean");
    end else begin
      $display("decimal_string_to_uint_parser verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("decimal_string_to_uint_parser verification failed");
    $finish;
  end

endmodule
